### design/cylw_pkg.sv
package cylw_pkg;

	// fixed image geometry and number format
	localparam int FRAC_BITS  = 16;
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int XW         = 10;
	localparam int YW         = 10;
	localparam int PIX_W      = 8;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	// command codes
	localparam logic FN_WRITE = 1'b0;
	localparam logic FN_WARP  = 1'b1;

	// derived datapath widths
	localparam int HALF_W  = $clog2(MAX_WIDTH);
	localparam int AX_W    = XW + 1;
	localparam int PC_W    = XW + 2;
	localparam int D_W     = 2 * AX_W - 1;
	localparam int W2_W    = 2 * CFG_W;
	localparam int ZR_W    = HALF_W + FRAC_BITS + 1;
	localparam int DB_W    = $clog2(ZR_W);
	localparam int DR_W    = 2 * ZR_W;
	localparam int Z_W     = HALF_W + FRAC_BITS + 2;
	localparam int AZ_W    = AX_W + Z_W;
	localparam int AZL_W   = (AZ_W + 1) / 2;
	localparam int AZH_W   = AZ_W - AZL_W;
	localparam int A0_W    = D_W + W2_W;
	localparam int A_W     = A0_W + 2 * FRAC_BITS;
	localparam int SW      = (A_W + 1) / 2;
	localparam int R_W     = 2 * SW;
	localparam int HZ_W    = HALF_W + Z_W;
	localparam int M_W     = HZ_W + 2;
	localparam int N_W     = PC_W + M_W;
	localparam int NM_W    = N_W - 1;
	localparam int SX_W    = NM_W + 2;
	localparam int TL_W    = SX_W - 1 - FRAC_BITS;
	localparam int WT_W    = 2 * FRAC_BITS + 2;
	localparam int PR_W    = WT_W + PIX_W;
	localparam int ACC_W   = PR_W + 2;
	localparam int BANK_AW = XW + YW - 2;
	localparam int BANK_D  = 1 << BANK_AW;

	// depth offset sequencer
	typedef enum logic {
		DEP_IDLE,
		DEP_RUN
	} dep_state_t;

	// item control carried down the pipeline
	typedef struct packed {
		logic             func;
		logic [XW-1:0]    x;
		logic [YW-1:0]    y;
		logic [PIX_W-1:0] pix;
		logic             neg;
	} ctl_t;

endpackage

### design/cylindrical_warp_bilinear_top.sv
// Cylindrical warp with bilinear sampling. Source pixels (func 0) and warp
// requests (func 1) share one command port and are taken one per clock
// whenever busy is low. Every request yields exactly one result, shown by
// done being high for a single cycle; writes give none. The receiver cannot
// stall, so results must be captured on the strobe. Each request passes
// through the 38-stage square-root pipeline and the two 51-stage divider
// lanes; the four bilinear neighbours come from four parity-banked image
// memories read in the same cycle. Writes are applied at the same pipeline
// stage as the reads, so every request sees exactly the pixels written
// before it. After reset and after each image_width write the block is busy
// while the depth offset is recomputed bit-serially.
module cylindrical_warp_bilinear_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            func,
	input  logic [cylw_pkg::XW-1:0]         x_pos,
	input  logic [cylw_pkg::YW-1:0]         y_pos,
	input  logic [cylw_pkg::PIX_W-1:0]      pixel_in,
	output logic                            done,
	output logic [cylw_pkg::PIX_W-1:0]      pixel_out,
	output logic                            inside_res,
	output logic [cylw_pkg::XW-1:0]         out_x,
	output logic [cylw_pkg::YW-1:0]         out_y,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cylw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cylw_pkg::CFG_W-1:0]      cfg_data
);
	import cylw_pkg::*;

	localparam int F = FRAC_BITS;

	// ---------------- configuration and clamped geometry ----------------
	logic [CFG_W-1:0]  width_q, height_q, w_use, h_use;
	logic [HALF_W-1:0] half, hh;
	logic              width_wr, accept;

	assign cfg_ready = 1'b1;
	assign width_wr  = cfg_valid && cfg_ready && (cfg_index == REG_WIDTH);
	assign accept    = start && !busy;

	always_comb begin
		priority if (width_q < CFG_W'(2)) begin
			w_use = CFG_W'(2);
		end else if (width_q > CFG_W'(MAX_WIDTH)) begin
			w_use = CFG_W'(MAX_WIDTH);
		end else begin
			w_use = width_q;
		end
		priority if (height_q < CFG_W'(2)) begin
			h_use = CFG_W'(2);
		end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
			h_use = CFG_W'(MAX_HEIGHT);
		end else begin
			h_use = height_q;
		end
	end

	assign half = w_use[HALF_W:1];
	assign hh   = h_use[HALF_W:1];

	// ---------------- depth offset sequencer ----------------
	dep_state_t        dep_state_q, dep_state_d;
	logic [DB_W-1:0]   dep_bit_q;
	logic [ZR_W-1:0]   dep_root_q, dep_cand, dep_root_nx;
	logic [DR_W-1:0]   dep_cand_sq, dep_rad;
	logic [W2_W-1:0]   w_sq;
	logic [2*HALF_W-1:0] half_sq;
	logic [Z_W-1:0]    z_q;
	logic              dep_last;

	assign w_sq        = w_use * w_use;
	assign half_sq     = half * half;
	assign dep_rad     = DR_W'(w_sq - W2_W'(half_sq)) << (2 * F);
	assign dep_cand    = dep_root_q | (ZR_W'(1) << dep_bit_q);
	assign dep_cand_sq = dep_cand * dep_cand;
	assign dep_root_nx = (dep_cand_sq <= dep_rad) ? dep_cand : dep_root_q;
	assign dep_last    = (dep_state_q == DEP_RUN) && !width_wr && (dep_bit_q == '0);
	assign busy        = (dep_state_q == DEP_RUN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_state_q <= DEP_RUN;
		end else begin
			dep_state_q <= dep_state_d;
		end
	end

	always_comb begin
		dep_state_d = dep_state_q;
		unique case (dep_state_q)
			DEP_IDLE: begin
				if (width_wr) dep_state_d = DEP_RUN;
			end
			DEP_RUN: begin
				if (!width_wr && dep_bit_q == '0) dep_state_d = DEP_IDLE;
			end
		endcase
	end

	// registers and root iteration, one root bit per cycle while running
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= CFG_W'(1024);
			height_q   <= CFG_W'(1024);
			dep_bit_q  <= DB_W'(ZR_W - 1);
			dep_root_q <= '0;
		end else begin
			if (width_wr) begin
				width_q    <= cfg_data;
				dep_bit_q  <= DB_W'(ZR_W - 1);
				dep_root_q <= '0;
			end else if (dep_state_q == DEP_RUN) begin
				dep_root_q <= dep_root_nx;
				if (dep_bit_q != '0) dep_bit_q <= dep_bit_q - DB_W'(1);
			end
			if (cfg_valid && cfg_ready && cfg_index == REG_HEIGHT) height_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (dep_last) z_q <= (Z_W'(half) << F) + Z_W'(dep_root_nx);
	end

	// ---------------- s1: centered coordinates ----------------
	logic signed [PC_W-1:0] pcx_c, pcy_c;
	logic [AX_W-1:0]        ax_c;
	logic                   vld_s1;
	ctl_t                   ctl_s1;
	logic signed [PC_W-1:0] pcx_s1, pcy_s1;
	logic [AX_W-1:0]        ax_s1;

	assign pcx_c = PC_W'(x_pos) - PC_W'(half);
	assign pcy_c = PC_W'(y_pos) - PC_W'(hh);
	assign ax_c  = pcx_c[PC_W-1] ? AX_W'(-pcx_c) : AX_W'(pcx_c);

	always_ff @(posedge clk) begin
		ctl_s1 <= '{func: func, x: x_pos, y: y_pos, pix: pixel_in, neg: 1'b0};
		pcx_s1 <= pcx_c;
		pcy_s1 <= pcy_c;
		ax_s1  <= ax_c;
	end

	// ---------------- s2: d, ax*z, half*z, w^2 ----------------
	logic [2*AX_W-1:0]      ax_sq;
	logic                   vld_s2;
	ctl_t                   ctl_s2;
	logic signed [PC_W-1:0] pcx_s2, pcy_s2;
	logic [D_W-1:0]         d_s2;
	logic [AZ_W-1:0]        axz_s2;
	logic [HZ_W-1:0]        hz_s2;
	logic [W2_W-1:0]        w2_s2;

	assign ax_sq = ax_s1 * ax_s1;

	always_ff @(posedge clk) begin
		ctl_s2 <= ctl_s1;
		pcx_s2 <= pcx_s1;
		pcy_s2 <= pcy_s1;
		d_s2   <= D_W'(half_sq) + D_W'(ax_sq);
		axz_s2 <= ax_s1 * z_q;
		hz_s2  <= half * z_q;
		w2_s2  <= w_sq;
	end

	// ---------------- s3: d*w^2 and partial squares of ax*z ----------------
	logic                   vld_s3;
	ctl_t                   ctl_s3;
	logic signed [PC_W-1:0] pcx_s3, pcy_s3;
	logic [D_W-1:0]         d_s3;
	logic [HZ_W-1:0]        hz_s3;
	logic [A0_W-1:0]        a0_s3;
	logic [2*AZH_W-1:0]     bhh_s3;
	logic [AZH_W+AZL_W-1:0] bhl_s3;
	logic [2*AZL_W-1:0]     bll_s3;
	logic [AZH_W-1:0]       axh;
	logic [AZL_W-1:0]       axl;

	assign axh = axz_s2[AZ_W-1:AZL_W];
	assign axl = axz_s2[AZL_W-1:0];

	always_ff @(posedge clk) begin
		ctl_s3 <= ctl_s2;
		pcx_s3 <= pcx_s2;
		pcy_s3 <= pcy_s2;
		d_s3   <= d_s2;
		hz_s3  <= hz_s2;
		a0_s3  <= d_s2 * w2_s2;
		bhh_s3 <= axh * axh;
		bhl_s3 <= axh * axl;
		bll_s3 <= axl * axl;
	end

	// ---------------- square root pipeline, one root bit per stage ----------------
	logic [R_W-1:0]         a_c, b_c;
	ctl_t                   ctl_sq_c;
	logic                   sq_vld  [0:SW];
	ctl_t                   sq_ctl  [0:SW];
	logic [R_W-1:0]         sq_rad  [0:SW];
	logic [SW+2:0]          sq_rem  [0:SW];
	logic [SW-1:0]          sq_root [0:SW];
	logic [D_W-1:0]         sq_d    [0:SW];
	logic [HZ_W-1:0]        sq_hz   [0:SW];
	logic signed [PC_W-1:0] sq_pcx  [0:SW];
	logic signed [PC_W-1:0] sq_pcy  [0:SW];

	assign a_c = R_W'(a0_s3) << (2 * F);
	assign b_c = (R_W'(bhh_s3) << (2 * AZL_W)) + (R_W'(bhl_s3) << (AZL_W + 1))
		+ R_W'(bll_s3);

	// negative radicand marks the point as outside
	always_comb begin
		ctl_sq_c     = ctl_s3;
		ctl_sq_c.neg = (b_c > a_c);
	end

	always_ff @(posedge clk) begin
		sq_ctl[0]     <= ctl_sq_c;
		sq_rad[0]     <= a_c - b_c;
		sq_rem[0]     <= '0;
		sq_root[0]    <= '0;
		sq_d[0]       <= d_s3;
		sq_hz[0]      <= hz_s3;
		sq_pcx[0]     <= pcx_s3;
		sq_pcy[0]     <= pcy_s3;
	end

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		logic [SW+2:0] rem_t, trial;
		logic          ge;

		assign rem_t = {sq_rem[i][SW:0], sq_rad[i][R_W-1 -: 2]};
		assign trial = {1'b0, sq_root[i], 2'b01};
		assign ge    = (rem_t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[i+1] <= 1'b0;
			end else begin
				sq_vld[i+1] <= sq_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_ctl[i+1]  <= sq_ctl[i];
			sq_rad[i+1]  <= sq_rad[i] << 2;
			sq_rem[i+1]  <= ge ? rem_t - trial : rem_t;
			sq_root[i+1] <= {sq_root[i][SW-2:0], ge};
			sq_d[i+1]    <= sq_d[i];
			sq_hz[i+1]   <= sq_hz[i];
			sq_pcx[i+1]  <= sq_pcx[i];
			sq_pcy[i+1]  <= sq_pcy[i];
		end
	end

	// ---------------- s5: m = half*z - s ----------------
	logic                   vld_s5;
	ctl_t                   ctl_s5;
	logic signed [M_W-1:0]  m_s5;
	logic [D_W-1:0]         d_s5;
	logic signed [PC_W-1:0] pcx_s5, pcy_s5;

	always_ff @(posedge clk) begin
		ctl_s5 <= sq_ctl[SW];
		m_s5   <= M_W'(sq_hz[SW]) - M_W'(sq_root[SW]);
		d_s5   <= sq_d[SW];
		pcx_s5 <= sq_pcx[SW];
		pcy_s5 <= sq_pcy[SW];
	end

	// ---------------- dividers: two lanes, one quotient bit per stage ----------------
	logic signed [N_W-1:0] nx_c, ny_c;
	logic                  dv_vld [0:NM_W];
	ctl_t                  dv_ctl [0:NM_W];
	logic [D_W-1:0]        dv_d   [0:NM_W];
	logic [NM_W-1:0]       dv_nx  [0:NM_W];
	logic [NM_W-1:0]       dv_ny  [0:NM_W];
	logic [D_W-1:0]        dv_rx  [0:NM_W];
	logic [D_W-1:0]        dv_ry  [0:NM_W];
	logic                  dv_sgx [0:NM_W];
	logic                  dv_sgy [0:NM_W];

	assign nx_c = pcx_s5 * m_s5;
	assign ny_c = pcy_s5 * m_s5;

	always_ff @(posedge clk) begin
		dv_ctl[0] <= ctl_s5;
		dv_d[0]   <= d_s5;
		dv_nx[0]  <= nx_c[N_W-1] ? NM_W'(-nx_c) : NM_W'(nx_c);
		dv_ny[0]  <= ny_c[N_W-1] ? NM_W'(-ny_c) : NM_W'(ny_c);
		dv_rx[0]  <= '0;
		dv_ry[0]  <= '0;
		dv_sgx[0] <= nx_c[N_W-1];
		dv_sgy[0] <= ny_c[N_W-1];
	end

	for (genvar i = 0; i < NM_W; i++) begin : g_div
		logic [D_W:0] rx_t, ry_t, dd;
		logic         gx, gy;

		assign dd   = {1'b0, dv_d[i]};
		assign rx_t = {dv_rx[i], dv_nx[i][NM_W-1]};
		assign ry_t = {dv_ry[i], dv_ny[i][NM_W-1]};
		assign gx   = (rx_t >= dd);
		assign gy   = (ry_t >= dd);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[i+1] <= 1'b0;
			end else begin
				dv_vld[i+1] <= dv_vld[i];
			end
		end

		always_ff @(posedge clk) begin
			dv_ctl[i+1] <= dv_ctl[i];
			dv_d[i+1]   <= dv_d[i];
			dv_nx[i+1]  <= {dv_nx[i][NM_W-2:0], gx};
			dv_ny[i+1]  <= {dv_ny[i][NM_W-2:0], gy};
			dv_rx[i+1]  <= gx ? D_W'(rx_t - dd) : D_W'(rx_t);
			dv_ry[i+1]  <= gy ? D_W'(ry_t - dd) : D_W'(ry_t);
			dv_sgx[i+1] <= dv_sgx[i];
			dv_sgy[i+1] <= dv_sgy[i];
		end
	end

	// ---------------- s7: source point, bounds, memory access ----------------
	logic [SX_W-1:0]  sx_c, sy_c;
	logic [NM_W-1:0]  qx, qy;
	logic [TL_W-1:0]  wlim, hlim;
	logic             inside_c;
	logic             vld_s7, inside_s7;
	ctl_t             ctl_s7;
	logic [XW-1:0]    tlx_s7;
	logic [YW-1:0]    tly_s7;
	logic [F-1:0]     dx_s7, dy_s7;

	assign qx   = dv_nx[NM_W];
	assign qy   = dv_ny[NM_W];
	assign sx_c = (dv_sgx[NM_W] ? SX_W'(0) - SX_W'(qx) : SX_W'(qx)) + (SX_W'(half) << F);
	assign sy_c = (dv_sgy[NM_W] ? SX_W'(0) - SX_W'(qy) : SX_W'(qy)) + (SX_W'(hh) << F);
	assign wlim = TL_W'(w_use) - TL_W'(2);
	assign hlim = TL_W'(h_use) - TL_W'(2);
	assign inside_c = !dv_ctl[NM_W].neg && !sx_c[SX_W-1] && !sy_c[SX_W-1]
		&& (sx_c[SX_W-2:F] <= wlim) && (sy_c[SX_W-2:F] <= hlim);

	always_ff @(posedge clk) begin
		ctl_s7    <= dv_ctl[NM_W];
		inside_s7 <= inside_c;
		tlx_s7    <= sx_c[F +: XW];
		tly_s7    <= sy_c[F +: YW];
		dx_s7     <= sx_c[F-1:0];
		dy_s7     <= sy_c[F-1:0];
	end

	// four image banks split by row and column parity
	logic [PIX_W-1:0] rd_s8 [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [PIX_W-1:0]   mem [BANK_D];
		logic [XW:0]        colp;
		logic [YW:0]        rowp;
		logic [BANK_AW-1:0] raddr, waddr;
		logic               we;

		assign colp  = {1'b0, tlx_s7} + (XW+1)'(tlx_s7[0] != b[0]);
		assign rowp  = {1'b0, tly_s7} + (YW+1)'(tly_s7[0] != b[1]);
		assign raddr = {rowp[YW-1:1], colp[XW-1:1]};
		assign waddr = {ctl_s7.y[YW-1:1], ctl_s7.x[XW-1:1]};
		assign we    = vld_s7 && (ctl_s7.func == FN_WRITE)
			&& (ctl_s7.x[0] == b[0]) && (ctl_s7.y[0] == b[1]);

		always_ff @(posedge clk) begin
			if (we) mem[waddr] <= ctl_s7.pix;
			rd_s8[b] <= mem[raddr];
		end
	end

	// ---------------- s8..s10: weights, products, sum ----------------
	logic             vld_s8, inside_s8, px_s8, py_s8;
	ctl_t             ctl_s8;
	logic [F-1:0]     dx_s8, dy_s8;
	logic [F:0]       ex, ey, fx, fy;
	logic             vld_s9, inside_s9;
	ctl_t             ctl_s9;
	logic [WT_W-1:0]  wt_s9 [4];
	logic [PIX_W-1:0] p_s9  [4];
	logic             vld_s10, inside_s10;
	ctl_t             ctl_s10;
	logic [PR_W-1:0]  pr_s10 [4];
	logic [ACC_W-1:0] acc;

	always_ff @(posedge clk) begin
		ctl_s8    <= ctl_s7;
		inside_s8 <= inside_s7;
		dx_s8     <= dx_s7;
		dy_s8     <= dy_s7;
		px_s8     <= tlx_s7[0];
		py_s8     <= tly_s7[0];
	end

	assign fx = {1'b0, dx_s8};
	assign fy = {1'b0, dy_s8};
	assign ex = {1'b1, {F{1'b0}}} - fx;
	assign ey = {1'b1, {F{1'b0}}} - fy;

	// neighbor k: bit0 = column step, bit1 = row step
	always_ff @(posedge clk) begin
		ctl_s9    <= ctl_s8;
		inside_s9 <= inside_s8;
		wt_s9[0]  <= ex * ey;
		wt_s9[1]  <= fx * ey;
		wt_s9[2]  <= ex * fy;
		wt_s9[3]  <= fx * fy;
		p_s9[0]   <= rd_s8[{py_s8, px_s8}];
		p_s9[1]   <= rd_s8[{py_s8, !px_s8}];
		p_s9[2]   <= rd_s8[{!py_s8, px_s8}];
		p_s9[3]   <= rd_s8[{!py_s8, !px_s8}];
	end

	always_ff @(posedge clk) begin
		ctl_s10    <= ctl_s9;
		inside_s10 <= inside_s9;
		for (int k = 0; k < 4; k++) begin
			pr_s10[k] <= wt_s9[k] * p_s9[k];
		end
	end

	assign acc = ACC_W'(pr_s10[0]) + ACC_W'(pr_s10[1]) + ACC_W'(pr_s10[2])
		+ ACC_W'(pr_s10[3]);

	// ---------------- valid chain ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			sq_vld[0] <= 1'b0;
			vld_s5    <= 1'b0;
			dv_vld[0] <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			vld_s9    <= 1'b0;
			vld_s10   <= 1'b0;
		end else begin
			vld_s1    <= accept;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			sq_vld[0] <= vld_s3;
			vld_s5    <= sq_vld[SW];
			dv_vld[0] <= vld_s5;
			vld_s7    <= dv_vld[NM_W];
			vld_s8    <= vld_s7;
			vld_s9    <= vld_s8;
			vld_s10   <= vld_s9;
		end
	end

	// ---------------- result register ----------------
	logic             done_q, inside_q;
	logic [PIX_W-1:0] pix_q;
	logic [XW-1:0]    ox_q;
	logic [YW-1:0]    oy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s10 && (ctl_s10.func == FN_WARP);
		end
	end

	always_ff @(posedge clk) begin
		inside_q <= inside_s10;
		pix_q    <= inside_s10 ? acc[2*F +: PIX_W] : '0;
		ox_q     <= ctl_s10.x;
		oy_q     <= ctl_s10.y;
	end

	assign done       = done_q;
	assign inside_res = inside_q;
	assign pixel_out  = pix_q;
	assign out_x      = ox_q;
	assign out_y      = oy_q;

	// ---------------- assertions ----------------
	a_req_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_WARP) |-> ##100 done)
		else $error("request did not produce a result on time");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && func == FN_WRITE) |-> ##100 !done)
		else $error("pixel write produced a result");

	a_inside_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pixel_out != '0) |-> inside_res)
		else $error("nonzero pixel for an outside point");

endmodule
